// ----- rtl/core/csqrt_pkg.sv -----
// Shared types and constants for the complex square root pipeline.
package csqrt_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned SqW   = 64;
	localparam int unsigned MagW  = 24;
	localparam int unsigned NumW  = 47;
	localparam logic [WordW-1:0] PosMax = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		CASE_IM_ZERO = 2'b00,
		CASE_RE_ZERO = 2'b01,
		CASE_GENERAL = 2'b10
	} case_t;

	typedef struct packed {
		case_t             kind;
		logic              re_neg;
		logic              im_neg;
		logic [WordW-1:0]  ra;
		logic [WordW-1:0]  ia;
		logic [WordW-1:0]  r1;
		logic [MagW-1:0]   mag;
	} side_t;

	function automatic logic [WordW-1:0] sat_mag(input logic [NumW-1:0] m);
		logic [WordW-1:0] r;
		r = (m > NumW'(PosMax)) ? PosMax : m[WordW-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/core/complex_square_root.sv -----
// Top level of the principal-branch complex square root pipeline.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_stall  | in_real, in_imag (Q15.16)
//   output  | out       | out_valid / out_stall| out_real, out_imag (Q15.16)
//
// One element is taken every cycle while in_stall is low. On its way from the input
// transfer to the earliest output transfer an element passes three front stages (abs, squares,
// argument select), 32 stages for |z|, one add stage, 24 stages for the
// magnitude root, 47 divider stages and the output register.
// Reset clears only the valid bits; no clearing pass is needed.
// The whole pipeline advances together; it freezes only while a result sits
// in the output register and the sink holds out_stall high.
module complex_square_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] in_real,
	input  logic [31:0] in_imag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_real,
	output logic [31:0] out_imag
);

	localparam int unsigned SideW = $bits(csqrt_pkg::side_t);

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Front stage 1: magnitudes, signs and the special-case class.
	logic                 v_s1;
	csqrt_pkg::side_t     sb_s1;
	logic                 re_neg_w;
	logic                 im_neg_w;
	logic [31:0]          ra_w;
	logic [31:0]          ia_w;
	csqrt_pkg::case_t     kind_w;

	assign re_neg_w = in_real[31];
	assign im_neg_w = in_imag[31];
	assign ra_w     = re_neg_w ? (32'd0 - in_real) : in_real;
	assign ia_w     = im_neg_w ? (32'd0 - in_imag) : in_imag;

	always_comb begin
		if (ia_w == 32'd0) begin
			kind_w = csqrt_pkg::CASE_IM_ZERO;
		end else if (ra_w == 32'd0) begin
			kind_w = csqrt_pkg::CASE_RE_ZERO;
		end else begin
			kind_w = csqrt_pkg::CASE_GENERAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1.kind   <= kind_w;
			sb_s1.re_neg <= re_neg_w;
			sb_s1.im_neg <= im_neg_w;
			sb_s1.ra     <= ra_w;
			sb_s1.ia     <= ia_w;
			sb_s1.r1     <= '0;
			sb_s1.mag    <= '0;
		end
	end

	// Stage 2: the two squares for |z|^2.
	logic             v_s2;
	csqrt_pkg::side_t sb_s2;
	logic [63:0]      sq_re_s2;
	logic [63:0]      sq_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2    <= sb_s1;
			sq_re_s2 <= 64'(sb_s1.ra) * 64'(sb_s1.ra);
			sq_im_s2 <= 64'(sb_s1.ia) * 64'(sb_s1.ia);
		end
	end

	// Stage 3: pick the first root's argument. The special cases finish
	// with this root, the general case gets |z| from it.
	logic             v_s3;
	csqrt_pkg::side_t sb_s3;
	logic [63:0]      arg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3 <= sb_s2;
			unique case (sb_s2.kind)
				csqrt_pkg::CASE_IM_ZERO: arg_s3 <= {16'd0, sb_s2.ra, 16'd0};
				csqrt_pkg::CASE_RE_ZERO: arg_s3 <= {17'd0, sb_s2.ia, 15'd0};
				default:                 arg_s3 <= sq_re_s2 + sq_im_s2;
			endcase
		end
	end

	logic             v_a;
	logic [31:0]      root_a;
	logic [SideW-1:0] sb_a_bits;
	csqrt_pkg::side_t sb_a;
	csqrt_pkg::side_t sb_a_upd;

	csqrt_isqrt #(.W(64), .SW(SideW)) u_isqrt_abs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s3),
		.arg    (arg_s3),
		.in_sb  (sb_s3),
		.out_v  (v_a),
		.root   (root_a),
		.out_sb (sb_a_bits)
	);

	assign sb_a = csqrt_pkg::side_t'(sb_a_bits);

	// The first root travels on as r1; the special cases take it as their result.
	always_comb begin
		sb_a_upd    = sb_a;
		sb_a_upd.r1 = root_a;
	end

	// Stage 4: (|z| + |re|) / 2 in Q32 for the magnitude root.
	logic             v_s4;
	csqrt_pkg::side_t sb_s4;
	logic [47:0]      arg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4  <= sb_a_upd;
			arg_s4 <= {({1'b0, root_a} + {1'b0, sb_a.ra}), 15'd0};
		end
	end

	logic             v_m;
	logic [23:0]      root_m;
	logic [SideW-1:0] sb_m_bits;
	csqrt_pkg::side_t sb_m;
	csqrt_pkg::side_t sb_m_upd;

	csqrt_isqrt #(.W(48), .SW(SideW)) u_isqrt_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s4),
		.arg    (arg_s4),
		.in_sb  (sb_s4),
		.out_v  (v_m),
		.root   (root_m),
		.out_sb (sb_m_bits)
	);

	assign sb_m = csqrt_pkg::side_t'(sb_m_bits);

	always_comb begin
		sb_m_upd     = sb_m;
		sb_m_upd.mag = root_m;
	end

	// Divider: |im| / (2 * mag) in Q16. Its quotient is ignored in the
	// special cases, where mag is meaningless.
	logic             v_d;
	logic [46:0]      quo_d;
	logic [SideW-1:0] sb_d_bits;
	csqrt_pkg::side_t sb_d;

	csqrt_div #(.NW(47), .DW(24), .SW(SideW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_m),
		.num    ({sb_m.ia, 15'd0}),
		.den    (root_m),
		.in_sb  (sb_m_upd),
		.out_v  (v_d),
		.quo    (quo_d),
		.out_sb (sb_d_bits)
	);

	assign sb_d = csqrt_pkg::side_t'(sb_d_bits);

	// Output register: select the branch and apply signs.
	logic [31:0] r_sat;
	logic [31:0] q_sat;
	logic [31:0] m_ext;
	logic [31:0] res_re;
	logic [31:0] res_im;

	assign r_sat = csqrt_pkg::sat_mag({15'd0, sb_d.r1});
	assign q_sat = csqrt_pkg::sat_mag(quo_d);
	assign m_ext = {8'd0, sb_d.mag};

	always_comb begin
		unique case (sb_d.kind)
			csqrt_pkg::CASE_IM_ZERO: begin
				res_re = sb_d.re_neg ? 32'd0 : r_sat;
				res_im = sb_d.re_neg ? r_sat : 32'd0;
			end
			csqrt_pkg::CASE_RE_ZERO: begin
				res_re = r_sat;
				res_im = sb_d.im_neg ? (32'd0 - r_sat) : r_sat;
			end
			default: begin
				if (sb_d.re_neg) begin
					res_re = q_sat;
					res_im = sb_d.im_neg ? (32'd0 - m_ext) : m_ext;
				end else begin
					res_re = m_ext;
					res_im = sb_d.im_neg ? (32'd0 - q_sat) : q_sat;
				end
			end
		endcase
	end

	logic        out_valid_q;
	logic [31:0] out_real_q;
	logic [31:0] out_imag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_real_q <= res_re;
			out_imag_q <= res_im;
		end
	end

	assign out_valid = out_valid_q;
	assign out_real  = out_real_q;
	assign out_imag  = out_imag_q;

`ifndef SYNTH
	// The principal branch never yields a negative real part.
	a_real_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_real[31])
		else $error("negative real part on output");

	// The input side stalls only behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// A frozen pipeline keeps its first stage intact.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && v_s1) |=> (v_s1 && $stable(sb_s1.ra) && $stable(sb_s1.ia)))
		else $error("first stage changed while frozen");
`endif

endmodule

// ----- rtl/core/csqrt_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, truncated.
module csqrt_isqrt #(
	parameter int unsigned W  = 64,
	parameter int unsigned SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [W-1:0]    arg,
	input  logic [SW-1:0]   in_sb,
	output logic            out_v,
	output logic [W/2-1:0]  root,
	output logic [SW-1:0]   out_sb
);

	localparam int unsigned N = W / 2;

	logic [W-1:0]  rem_s [N];
	logic [W-1:0]  res_s [N];
	logic [SW-1:0] sb_s  [N];
	logic          v_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [W-1:0] StepBit = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
		logic [W-1:0]  rem_in;
		logic [W-1:0]  res_in;
		logic [SW-1:0] sb_in;
		logic          v_in;
		logic [W:0]    trial;

		if (k == 0) begin : g_first
			assign rem_in = arg;
			assign res_in = '0;
			assign sb_in  = in_sb;
			assign v_in   = in_v;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign sb_in  = sb_s[k-1];
			assign v_in   = v_s[k-1];
		end

		assign trial = {1'b0, res_in} + {1'b0, StepBit};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sb_in;
				if ({1'b0, rem_in} >= trial) begin
					rem_s[k] <= rem_in - trial[W-1:0];
					res_s[k] <= (res_in >> 1) + StepBit;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign out_v  = v_s[N-1];
	assign root   = res_s[N-1][N-1:0];
	assign out_sb = sb_s[N-1];

endmodule

// ----- rtl/core/csqrt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module csqrt_div #(
	parameter int unsigned NW = 47,
	parameter int unsigned DW = 24,
	parameter int unsigned SW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [NW-1:0]  num,
	input  logic [DW-1:0]  den,
	input  logic [SW-1:0]  in_sb,
	output logic           out_v,
	output logic [NW-1:0]  quo,
	output logic [SW-1:0]  out_sb
);

	logic [NW-1:0] num_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [SW-1:0] sb_s  [NW];
	logic          v_s   [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [NW-1:0] num_in;
		logic [NW-1:0] quo_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [SW-1:0] sb_in;
		logic          v_in;
		logic [DW:0]   shifted;

		if (k == 0) begin : g_first
			assign num_in = num;
			assign quo_in = '0;
			assign rem_in = '0;
			assign den_in = den;
			assign sb_in  = in_sb;
			assign v_in   = in_v;
		end else begin : g_next
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign sb_in  = sb_s[k-1];
			assign v_in   = v_s[k-1];
		end

		assign shifted = {rem_in, num_in[NW-1-k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= num_in;
				den_s[k] <= den_in;
				sb_s[k]  <= sb_in;
				if (shifted >= {1'b0, den_in}) begin
					rem_s[k] <= DW'(shifted - {1'b0, den_in});
					quo_s[k] <= {quo_in[NW-2:0], 1'b1};
				end else begin
					rem_s[k] <= shifted[DW-1:0];
					quo_s[k] <= {quo_in[NW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_v  = v_s[NW-1];
	assign quo    = quo_s[NW-1];
	assign out_sb = sb_s[NW-1];

endmodule
